// File: rtl/npg_pkg.sv
// ----------------------------------------------------------------------------
// npg_pkg
// Shared constants, control word layout and microcode for the next
// permutation generator.
// ----------------------------------------------------------------------------
`default_nettype none

package npg_pkg;

  localparam int MAX_LEN   = 8;
  localparam int ELEM_BITS = 8;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CFG_W     = 4;
  localparam int STEP_W    = 5;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [STEP_W-1:0]    step_t;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // read address select
  localparam logic [2:0] RA_N_M1  = 3'd0;
  localparam logic [2:0] RA_HI_M1 = 3'd1;
  localparam logic [2:0] RA_HI_M2 = 3'd2;
  localparam logic [2:0] RA_K_M1  = 3'd3;
  localparam logic [2:0] RA_LO    = 3'd4;
  localparam logic [2:0] RA_HI    = 3'd5;
  localparam logic [2:0] RA_K     = 3'd6;

  localparam logic [1:0] HI_HOLD     = 2'd0;
  localparam logic [1:0] HI_LOAD_NM1 = 2'd1;
  localparam logic [1:0] HI_DEC      = 2'd2;

  localparam logic [1:0] LO_HOLD      = 2'd0;
  localparam logic [1:0] LO_LOAD_HIM1 = 2'd1;
  localparam logic [1:0] LO_INC       = 2'd2;

  localparam logic [2:0] K_HOLD     = 3'd0;
  localparam logic [2:0] K_LOAD_NM1 = 3'd1;
  localparam logic [2:0] K_DEC      = 3'd2;
  localparam logic [2:0] K_CLR      = 3'd3;
  localparam logic [2:0] K_INC      = 3'd4;

  localparam logic [1:0] A_HOLD = 2'd0;
  localparam logic [1:0] A_RD   = 2'd1;
  localparam logic [1:0] A_B    = 2'd2;

  localparam logic [1:0] MV_HOLD = 2'd0;
  localparam logic [1:0] MV_CLR  = 2'd1;
  localparam logic [1:0] MV_SET  = 2'd2;

  localparam logic [1:0] WA_LO = 2'd0;
  localparam logic [1:0] WA_HI = 2'd1;
  localparam logic [1:0] WA_K  = 2'd2;

  localparam logic WD_A = 1'b0;
  localparam logic WD_B = 1'b1;

  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_LT2      = 3'd2;
  localparam logic [2:0] C_B_LT_A   = 3'd3;
  localparam logic [2:0] C_HI_ONE   = 3'd4;
  localparam logic [2:0] C_LO_GE_HI = 3'd5;
  localparam logic [2:0] C_N_ZERO   = 3'd6;
  localparam logic [2:0] C_K_LAST   = 3'd7;

  localparam step_t S_START = 5'd0;
  localparam step_t S_PLOOP = 5'd2;
  localparam step_t S_FOUND = 5'd6;
  localparam step_t S_KLOOP = 5'd7;
  localparam step_t S_SWAP  = 5'd10;
  localparam step_t S_RLOOP = 5'd12;
  localparam step_t S_EMIT  = 5'd17;
  localparam step_t S_ERD   = 5'd18;
  localparam step_t S_DONE  = 5'd22;

  typedef struct packed {
    logic [2:0] ra_sel;
    logic [1:0] hi_op;
    logic [1:0] lo_op;
    logic [2:0] k_op;
    logic [1:0] a_op;
    logic       b_ld;
    logic [1:0] mv_op;
    logic       wr;
    logic [1:0] wa_sel;
    logic       wd_sel;
    logic       emit;
    logic [2:0] cond;
    step_t      target;
    logic       done;
  } uop_t;

  typedef struct packed {
    logic lt2;
    logic n_zero;
    logic b_lt_a;
    logic hi_one;
    logic lo_ge_hi;
    logic k_last;
    logic out_free;
  } stat_t;

  localparam uop_t UOP_NOP = '{
    ra_sel: RA_N_M1, hi_op: HI_HOLD, lo_op: LO_HOLD, k_op: K_HOLD,
    a_op: A_HOLD, b_ld: 1'b0, mv_op: MV_HOLD, wr: 1'b0, wa_sel: WA_LO,
    wd_sel: WD_A, emit: 1'b0, cond: C_NEVER, target: S_START, done: 1'b0
  };

  function automatic uop_t ucode(input step_t step);
    uop_t u;
    u = UOP_NOP;
    case (step)
      5'd0: begin
        u.ra_sel = RA_N_M1; u.hi_op = HI_LOAD_NM1; u.mv_op = MV_CLR;
        u.cond = C_LT2; u.target = S_EMIT;
      end
      5'd1: begin
        u.a_op = A_RD; u.ra_sel = RA_HI_M1;
      end
      5'd2: begin
        u.b_ld = 1'b1;
      end
      5'd3: begin
        u.cond = C_B_LT_A; u.target = S_FOUND;
      end
      5'd4: begin
        u.cond = C_HI_ONE; u.target = S_EMIT;
      end
      5'd5: begin
        u.a_op = A_B; u.hi_op = HI_DEC; u.ra_sel = RA_HI_M2;
        u.cond = C_ALWAYS; u.target = S_PLOOP;
      end
      5'd6: begin
        u.lo_op = LO_LOAD_HIM1; u.k_op = K_LOAD_NM1; u.ra_sel = RA_N_M1;
        u.mv_op = MV_SET;
      end
      5'd7: begin
        u.a_op = A_RD;
      end
      5'd8: begin
        u.cond = C_B_LT_A; u.target = S_SWAP;
      end
      5'd9: begin
        u.k_op = K_DEC; u.ra_sel = RA_K_M1; u.cond = C_ALWAYS; u.target = S_KLOOP;
      end
      5'd10: begin
        u.wr = 1'b1; u.wa_sel = WA_LO; u.wd_sel = WD_A;
      end
      5'd11: begin
        u.wr = 1'b1; u.wa_sel = WA_K; u.wd_sel = WD_B;
        u.hi_op = HI_LOAD_NM1; u.lo_op = LO_INC;
      end
      5'd12: begin
        u.ra_sel = RA_LO; u.cond = C_LO_GE_HI; u.target = S_EMIT;
      end
      5'd13: begin
        u.a_op = A_RD; u.ra_sel = RA_HI;
      end
      5'd14: begin
        u.b_ld = 1'b1;
      end
      5'd15: begin
        u.wr = 1'b1; u.wa_sel = WA_LO; u.wd_sel = WD_B;
      end
      5'd16: begin
        u.wr = 1'b1; u.wa_sel = WA_HI; u.wd_sel = WD_A;
        u.lo_op = LO_INC; u.hi_op = HI_DEC; u.cond = C_ALWAYS; u.target = S_RLOOP;
      end
      5'd17: begin
        u.k_op = K_CLR; u.cond = C_N_ZERO; u.target = S_DONE;
      end
      5'd18: begin
        u.ra_sel = RA_K;
      end
      5'd19: begin
        u.ra_sel = RA_K; u.emit = 1'b1;
      end
      5'd20: begin
        u.cond = C_K_LAST; u.target = S_DONE;
      end
      5'd21: begin
        u.k_op = K_INC; u.cond = C_ALWAYS; u.target = S_ERD;
      end
      default: begin
        u.done = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// File: rtl/next_permutation_generator.sv
// ----------------------------------------------------------------------------
// next_permutation_generator
// Steps a small stored array to its next lexicographic permutation.
//
// Input channel (in_valid/in_stall): a write beat stores value at index
// and does not raise in_stall. An advance beat runs the microprogram: find
// the rightmost ascent, swap it with the rightmost larger element, reverse
// the suffix, then return one result beat per element in use, position
// order, with advanced set if a next permutation existed and last on the
// final beat. in_stall is high while an advance runs and drops after the
// final result is in the output register, even if it is not yet taken.
// The single read port of the element store limits the microprogram to
// one access per microcode step.
// Output channel (out_valid/out_stall): one result register. A stall holds
// the beat and the sequencer waits at its emit step. cfg_we writes
// length_in_use (saturated to 8); the user must write it only while idle,
// as the block itself does not enforce this. Synchronous reset clears the
// sequencer, output valid and length; the element store is undefined until
// written.
// ----------------------------------------------------------------------------
`default_nettype none

module next_permutation_generator (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [npg_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      kind,
  input  wire logic [2:0]                index,
  input  wire logic [7:0]                value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     position,
  output logic [7:0]                     element,
  output logic                           advanced,
  output logic                           last
);

  npg_pkg::uop_t  uop;
  npg_pkg::stat_t stat;
  logic           busy;
  logic           in_acc;
  logic           start;
  logic           wr_item;

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && (kind == npg_pkg::KIND_ADVANCE);
  assign wr_item  = in_acc && (kind == npg_pkg::KIND_WRITE);

  npg_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .uop   (uop),
    .busy  (busy)
  );

  npg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr_item   (wr_item),
    .index     (index),
    .value     (value),
    .uop       (uop),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .position  (position),
    .element   (element),
    .advanced  (advanced),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !$rose(out_valid))
    else $error("result loaded while sequencer idle");

  a_start_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(in_valid && kind == npg_pkg::KIND_ADVANCE))
    else $error("sequencer started without an advance beat");

  a_more_results_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && !out_stall |=> busy)
    else $error("sequencer stopped before the final result");
`endif

endmodule

`default_nettype wire

// File: rtl/npg_ram.sv
// ----------------------------------------------------------------------------
// npg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/npg_useq.sv
// ----------------------------------------------------------------------------
// npg_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_useq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire npg_pkg::stat_t stat,
  output npg_pkg::uop_t       uop,
  output logic                busy
);

  npg_pkg::step_t step;
  npg_pkg::step_t step_next;
  logic           busy_next;
  logic           take;
  logic           hold;

  always_comb begin
    uop = busy ? npg_pkg::ucode(step) : npg_pkg::UOP_NOP;
  end

  always_comb begin
    case (uop.cond)
      npg_pkg::C_NEVER:    take = 1'b0;
      npg_pkg::C_ALWAYS:   take = 1'b1;
      npg_pkg::C_LT2:      take = stat.lt2;
      npg_pkg::C_B_LT_A:   take = stat.b_lt_a;
      npg_pkg::C_HI_ONE:   take = stat.hi_one;
      npg_pkg::C_LO_GE_HI: take = stat.lo_ge_hi;
      npg_pkg::C_N_ZERO:   take = stat.n_zero;
      npg_pkg::C_K_LAST:   take = stat.k_last;
      default:             take = 1'b0;
    endcase
  end

  assign hold = uop.emit && !stat.out_free;

  always_comb begin
    step_next = step;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        step_next = npg_pkg::S_START;
      end
    end else if (uop.done) begin
      busy_next = 1'b0;
    end else if (!hold) begin
      step_next = take ? uop.target : step + npg_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= npg_pkg::S_START;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/npg_dpath.sv
// ----------------------------------------------------------------------------
// npg_dpath
// Datapath: element store, pointers, operand registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module npg_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [npg_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      wr_item,
  input  wire logic [2:0]                index,
  input  wire logic [7:0]                value,
  input  wire npg_pkg::uop_t             uop,
  output npg_pkg::stat_t                 stat,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output logic [2:0]                     position,
  output logic [7:0]                     element,
  output logic                           advanced,
  output logic                           last
);

  npg_pkg::len_t  n;
  npg_pkg::idx_t  hi;
  npg_pkg::idx_t  lo;
  npg_pkg::idx_t  k;
  npg_pkg::idx_t  n_m1;
  npg_pkg::elem_t a;
  npg_pkg::elem_t b;
  logic           moved;

  npg_pkg::idx_t  raddr;
  npg_pkg::idx_t  waddr;
  npg_pkg::elem_t wdata;
  npg_pkg::elem_t rdata;
  logic           we;
  logic           item_ok;
  logic           load_out;

  assign n_m1 = npg_pkg::IDX_W'(n - npg_pkg::len_t'(1));

  // config: saturate to the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cfg_we) begin
      if (32'(cfg_wdata) > npg_pkg::MAX_LEN) begin
        n <= npg_pkg::len_t'(npg_pkg::MAX_LEN);
      end else begin
        n <= npg_pkg::len_t'(cfg_wdata);
      end
    end
  end

  always_comb begin
    case (uop.ra_sel)
      npg_pkg::RA_N_M1:  raddr = n_m1;
      npg_pkg::RA_HI_M1: raddr = hi - npg_pkg::idx_t'(1);
      npg_pkg::RA_HI_M2: raddr = hi - npg_pkg::idx_t'(2);
      npg_pkg::RA_K_M1:  raddr = k - npg_pkg::idx_t'(1);
      npg_pkg::RA_LO:    raddr = lo;
      npg_pkg::RA_HI:    raddr = hi;
      npg_pkg::RA_K:     raddr = k;
      default:           raddr = k;
    endcase
  end

  assign item_ok = wr_item && (32'(index) < npg_pkg::MAX_LEN);

  always_comb begin
    we    = uop.wr || item_ok;
    waddr = npg_pkg::idx_t'(index);
    wdata = npg_pkg::elem_t'(value);
    if (uop.wr) begin
      case (uop.wa_sel)
        npg_pkg::WA_LO: waddr = lo;
        npg_pkg::WA_HI: waddr = hi;
        npg_pkg::WA_K:  waddr = k;
        default:        waddr = k;
      endcase
      wdata = (uop.wd_sel == npg_pkg::WD_B) ? b : a;
    end
  end

  npg_ram #(
    .WIDTH (npg_pkg::ELEM_BITS),
    .DEPTH (npg_pkg::MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    case (uop.hi_op)
      npg_pkg::HI_LOAD_NM1: hi <= n_m1;
      npg_pkg::HI_DEC:      hi <= hi - npg_pkg::idx_t'(1);
      default:              hi <= hi;
    endcase
    case (uop.lo_op)
      npg_pkg::LO_LOAD_HIM1: lo <= hi - npg_pkg::idx_t'(1);
      npg_pkg::LO_INC:       lo <= lo + npg_pkg::idx_t'(1);
      default:               lo <= lo;
    endcase
    case (uop.k_op)
      npg_pkg::K_LOAD_NM1: k <= n_m1;
      npg_pkg::K_DEC:      k <= k - npg_pkg::idx_t'(1);
      npg_pkg::K_CLR:      k <= '0;
      npg_pkg::K_INC:      k <= k + npg_pkg::idx_t'(1);
      default:             k <= k;
    endcase
    case (uop.a_op)
      npg_pkg::A_RD: a <= rdata;
      npg_pkg::A_B:  a <= b;
      default:       a <= a;
    endcase
    if (uop.b_ld) begin
      b <= rdata;
    end
    case (uop.mv_op)
      npg_pkg::MV_CLR: moved <= 1'b0;
      npg_pkg::MV_SET: moved <= 1'b1;
      default:         moved <= moved;
    endcase
  end

  assign stat.lt2      = n < npg_pkg::len_t'(2);
  assign stat.n_zero   = n == '0;
  assign stat.b_lt_a   = b < a;
  assign stat.hi_one   = hi == npg_pkg::idx_t'(1);
  assign stat.lo_ge_hi = lo >= hi;
  assign stat.k_last   = (npg_pkg::len_t'(k) + npg_pkg::len_t'(1)) == n;
  assign stat.out_free = !out_valid || !out_stall;

  assign load_out = uop.emit && stat.out_free;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      position <= 3'(k);
      element  <= 8'(rdata);
      advanced <= moved;
      last     <= stat.k_last;
    end
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for next_permutation_generator. A queue of write and advance
// beats feeds a clocked driver. A clocked monitor checks every result beat
// against a shadow copy of the element store, stepped to its next
// lexicographic order in the same way as the block. Phases change the length
// setting while the block is idle and vary sender gaps and receiver stalls,
// including one long receiver hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 150;
  localparam int LIMIT  = 1000000;
  localparam int HOLD   = 400;

  typedef struct {
    logic           kind;
    npg_pkg::idx_t  index;
    npg_pkg::elem_t value;
  } perm_cmd_t;

  typedef struct {
    npg_pkg::idx_t  position;
    npg_pkg::elem_t element;
    logic           advanced;
    logic           last;
  } perm_elem_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [npg_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic                      kind      = npg_pkg::KIND_WRITE;
  logic [2:0]                index     = '0;
  logic [7:0]                value     = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                position;
  logic [7:0]                element;
  logic                      advanced;
  logic                      last;

  next_permutation_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .index     (index),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .element   (element),
    .advanced  (advanced),
    .last      (last)
  );

  always #6 clk = ~clk;

  perm_cmd_t                 cmd_queue[$];
  perm_elem_t                due_elements[$];
  npg_pkg::elem_t            shadow_perm[npg_pkg::MAX_LEN];
  logic [npg_pkg::CFG_W-1:0] shadow_len = '0;

  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_arm = 0;
  bit  hold_fired = 0;
  int  hold_left = 0;
  logic in_taken = 1'b0;

  int  cycles = 0;
  int  mismatches = 0;
  int  n_writes = 0;
  int  n_advances = 0;
  int  n_stepped = 0;
  int  n_results = 0;
  int  n_settings = 0;
  int  n_backed_up = 0;
  perm_cmd_t  drv_cmd;
  perm_elem_t got_elem, want_elem;

  // shadow of the block: store a value, or step to the next order and stream
  task step_permutation(input perm_cmd_t c);
    int             n, p, j, lo, hi, i;
    npg_pkg::elem_t t;
    logic           moved;
    if (c.kind == npg_pkg::KIND_WRITE) begin
      shadow_perm[c.index] = c.value;
      n_writes++;
    end else begin
      n = (shadow_len > npg_pkg::MAX_LEN) ? npg_pkg::MAX_LEN : int'(shadow_len);
      moved = 1'b0;
      if (n >= 2) begin
        p = n - 1;
        while (p > 0 && shadow_perm[p-1] >= shadow_perm[p]) p--;
        if (p > 0) begin
          p--;
          j = n - 1;
          while (shadow_perm[j] <= shadow_perm[p]) j--;
          t = shadow_perm[p]; shadow_perm[p] = shadow_perm[j]; shadow_perm[j] = t;
          lo = p + 1;
          hi = n - 1;
          while (lo < hi) begin
            t = shadow_perm[lo]; shadow_perm[lo] = shadow_perm[hi]; shadow_perm[hi] = t;
            lo++;
            hi--;
          end
          moved = 1'b1;
        end
      end
      n_advances++;
      if (moved) n_stepped++;
      for (i = 0; i < n; i++)
        due_elements.push_back('{npg_pkg::idx_t'(i), shadow_perm[i], moved, (i == n - 1)});
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, due_elements.size());
      $display("status: fail");
      $finish;
    end
  end

  // input beat accepted
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      step_permutation('{kind, index, value});
    if (!rst && in_valid && in_stall && out_stall) n_backed_up++;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        drv_cmd = cmd_queue.pop_front();
        in_valid <= 1'b1;
        kind <= drv_cmd.kind;
        index <= drv_cmd.index;
        value <= drv_cmd.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a one-off long hold-off
  always @(negedge clk) begin
    if (hold_arm && !hold_fired) begin
      hold_fired = 1;
      hold_left = HOLD;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_elem = '{position, element, advanced, last};
      n_results++;
      if (due_elements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: pos %0d elem %0d adv %0b last %0b",
                   position, element, advanced, last);
      end else begin
        want_elem = due_elements.pop_front();
        if (got_elem.position !== want_elem.position ||
            got_elem.element  !== want_elem.element  ||
            got_elem.advanced !== want_elem.advanced ||
            got_elem.last     !== want_elem.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch on result %0d: expected pos %0d elem %0d adv %0b last %0b,",
                      " got pos %0d elem %0d adv %0b last %0b"},
                     n_results, want_elem.position, want_elem.element, want_elem.advanced,
                     want_elem.last, position, element, advanced, last);
        end
      end
    end
  end

  task queue_cmd(input logic k, input int idx, input int val);
    cmd_queue.push_back('{k, npg_pkg::idx_t'(idx), npg_pkg::elem_t'(val)});
  endtask

  task write_length(input int len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len[npg_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_len = len[npg_pkg::CFG_W-1:0];
    n_settings++;
  endtask

  task wait_drained;
    @(posedge clk);
    while (cmd_queue.size() != 0 || in_valid || due_elements.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task random_phase(input int len, input int snd, input int rcv, input int count);
    int n, issued, r, i, reps, spread;
    int pool[3];
    write_length(len);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    n = (len > npg_pkg::MAX_LEN) ? npg_pkg::MAX_LEN : len;
    issued = 0;
    while (issued < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // fresh array from a small pool of values, then walk its orders
        for (i = 0; i < 3; i++) pool[i] = $urandom_range(0, 255);
        spread = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
          queue_cmd(npg_pkg::KIND_WRITE, i, pool[$urandom_range(0, spread)]);
        reps = $urandom_range(1, 10);
        for (i = 0; i < reps; i++)
          queue_cmd(npg_pkg::KIND_ADVANCE, $urandom_range(0, 7), $urandom_range(0, 255));
        issued += n + reps;
      end else if (r < 85) begin
        reps = $urandom_range(1, 4);
        for (i = 0; i < reps; i++)
          queue_cmd(npg_pkg::KIND_ADVANCE, $urandom_range(0, 7), $urandom_range(0, 255));
        issued += reps;
      end else begin
        queue_cmd(npg_pkg::KIND_WRITE, $urandom_range(0, 7), $urandom_range(0, 255));
        issued++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: ascending with repeats, then descending, then odd lengths
    write_length(8);
    queue_cmd(npg_pkg::KIND_WRITE, 0, 0);
    queue_cmd(npg_pkg::KIND_WRITE, 1, 17);
    queue_cmd(npg_pkg::KIND_WRITE, 2, 17);
    queue_cmd(npg_pkg::KIND_WRITE, 3, 40);
    queue_cmd(npg_pkg::KIND_WRITE, 4, 90);
    queue_cmd(npg_pkg::KIND_WRITE, 5, 128);
    queue_cmd(npg_pkg::KIND_WRITE, 6, 200);
    queue_cmd(npg_pkg::KIND_WRITE, 7, 255);
    queue_cmd(npg_pkg::KIND_ADVANCE, 0, 0);
    queue_cmd(npg_pkg::KIND_ADVANCE, 7, 255);
    queue_cmd(npg_pkg::KIND_WRITE, 0, 255);
    queue_cmd(npg_pkg::KIND_WRITE, 1, 200);
    queue_cmd(npg_pkg::KIND_WRITE, 2, 128);
    queue_cmd(npg_pkg::KIND_WRITE, 3, 90);
    queue_cmd(npg_pkg::KIND_WRITE, 4, 40);
    queue_cmd(npg_pkg::KIND_WRITE, 5, 17);
    queue_cmd(npg_pkg::KIND_WRITE, 6, 17);
    queue_cmd(npg_pkg::KIND_WRITE, 7, 0);
    queue_cmd(npg_pkg::KIND_ADVANCE, 5, 85);
    wait_drained();
    write_length(0);
    queue_cmd(npg_pkg::KIND_ADVANCE, 2, 170);
    wait_drained();
    write_length(1);
    queue_cmd(npg_pkg::KIND_ADVANCE, 0, 0);
    wait_drained();
    write_length(15);
    queue_cmd(npg_pkg::KIND_WRITE, 7, 255);
    queue_cmd(npg_pkg::KIND_ADVANCE, 3, 60);
    wait_drained();

    random_phase(8, 0, 0, 60);
    random_phase(3, 55, 0, 50);
    random_phase(2, 0, 55, 50);
    random_phase(4, 19, 19, 60);
    hold_arm = 1;
    random_phase(5, 0, 0, 60);
    random_phase(15, 55, 0, 50);
    random_phase(1, 19, 19, 30);
    random_phase(0, 0, 0, 20);
    random_phase(6, 0, 55, 40);
    random_phase(7, 19, 19, 40);

    $display("covered %0d writes and %0d advances (%0d stepped, %0d already in final order)",
             n_writes, n_advances, n_stepped, n_advances - n_stepped);
    $display("%0d result beats over %0d length settings, %0d cycles of input back-pressure",
             n_results, n_settings, n_backed_up);
    if (mismatches == 0 && due_elements.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, due_elements.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: next_permutation_generator.f
rtl/npg_pkg.sv
rtl/npg_ram.sv
rtl/npg_useq.sv
rtl/npg_dpath.sv
rtl/next_permutation_generator.sv
verif/tb.sv
